// File: hw/rtl/bdq_pkg.sv
// bdq_pkg: shared types and constants of the bounded deque with search
// request and result layouts, command codes, internal operation codes
// no dependencies
package bdq_pkg;

  // field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 5;

  // default store depth and depth of the queues between the parts
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // command codes as they arrive on the request port
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_REAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd4;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_INS_FRONT,
    OP_INS_REAR,
    OP_REM_FRONT,
    OP_REM_REAR,
    OP_SEARCH,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
  } op_t;

endpackage

// File: hw/rtl/bdq_fifo.sv
// bdq_fifo: small first-in first-out queue of any packed type
// used for the operation queue and the result queue
// no dependencies
module bdq_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CNT_W = $clog2(Depth + 1);

  T                 slot_q [Depth];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  // pointer and fill count update with wrap at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(Depth - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(Depth - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/bdq_front.sv
// bdq_front: accepts requests, decodes the command into an operation
// and queues it for the back end; depends on bdq_pkg and bdq_fifo
module bdq_front #(
  parameter int unsigned QueueDepth = bdq_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bdq_pkg::req_t req_i,
  output logic          full_o,
  output logic          op_valid_o,
  input  logic          op_pop_i,
  output bdq_pkg::op_t  op_o
);
  import bdq_pkg::*;

  op_t  op_in;
  logic op_empty;

  // command decode, unused codes become a no-op
  always_comb begin
    op_in.value = req_i.value;
    unique case (req_i.command)
      CMD_INS_FRONT: op_in.op = OP_INS_FRONT;
      CMD_INS_REAR:  op_in.op = OP_INS_REAR;
      CMD_REM_FRONT: op_in.op = OP_REM_FRONT;
      CMD_REM_REAR:  op_in.op = OP_REM_REAR;
      CMD_SEARCH:    op_in.op = OP_SEARCH;
      default:       op_in.op = OP_NOP;
    endcase
  end

  // operation queue toward the back end
  bdq_fifo #(
    .T    (op_t),
    .Depth(QueueDepth)
  ) u_op_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (op_in),
    .full_o (full_o),
    .pop_i  (op_pop_i),
    .data_o (op_o),
    .empty_o(op_empty)
  );

  assign op_valid_o = !op_empty;

endmodule

// File: hw/rtl/bdq_back.sv
// bdq_back: element store, front pointer and count, and the search scanner
// executes one operation at a time; depends on bdq_pkg
module bdq_back #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  bdq_pkg::op_t  op_i,
  output logic          op_pop_o,
  input  logic          rsp_full_i,
  output logic          rsp_push_o,
  output bdq_pkg::rsp_t rsp_o
);
  import bdq_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // cell holding element at offset from the front, wrapping at the depth
  function automatic logic [IDX_W-1:0] cell_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // count to result field width
  function automatic logic [POS_W-1:0] to_field(input logic [CNT_W-1:0] v);
    logic [CNT_W+POS_W-1:0] w;
    w = {{POS_W{1'b0}}, v};
    return w[POS_W-1:0];
  endfunction

  logic                    state_q, state_d;
  logic [IDX_W-1:0]        front_q, front_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        issue_q, issue_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [CNT_W-1:0]        rd_off_q, rd_off_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  logic signed [VAL_W-1:0] rdata_q;
  logic signed [VAL_W-1:0] mem_q [DEPTH];

  logic             is_full, is_empty;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr, new_front;
  status_e          status;
  logic [CNT_W-1:0] position;

  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign rd_addr  = cell_of(front_q, issue_q);

  // operation sequencer
  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    issue_d    = issue_q;
    rd_vld_d   = rd_vld_q;
    rd_off_d   = rd_off_q;
    key_d      = key_q;
    op_pop_o   = 1'b0;
    rsp_push_o = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cell_of(front_q, count_q);
    rd_en      = 1'b0;
    new_front  = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
    status     = ST_OK;
    position   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (op_valid_i && !rsp_full_i) begin
          op_pop_o   = 1'b1;
          rsp_push_o = 1'b1;
          unique case (op_i.op)
            OP_INS_FRONT: begin
              if (is_full) begin
                status = ST_FULL;
              end else begin
                front_d = new_front;
                wr_en   = 1'b1;
                wr_addr = new_front;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_INS_REAR: begin
              if (is_full) begin
                status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_REM_FRONT: begin
              if (is_empty) begin
                status = ST_EMPTY;
              end else begin
                front_d = cell_of(front_q, CNT_W'(1));
                count_d = count_q - CNT_W'(1);
              end
            end
            OP_REM_REAR: begin
              if (is_empty) begin
                status = ST_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            OP_SEARCH: begin
              if (is_empty) begin
                status = ST_EMPTY;
              end else begin
                // result comes later from the scan
                rsp_push_o = 1'b0;
                key_d      = op_i.value;
                issue_d    = '0;
                rd_vld_d   = 1'b0;
                state_d    = S_SCAN;
              end
            end
            default: begin
              status = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        // compare the element read last cycle, then issue the next read
        // the compared element is held while the result queue is full
        if (rd_vld_q && (rdata_q == key_q)) begin
          if (!rsp_full_i) begin
            rsp_push_o = 1'b1;
            status     = ST_OK;
            position   = rd_off_q + CNT_W'(1);
            rd_vld_d   = 1'b0;
            state_d    = S_IDLE;
          end
        end else if (rd_vld_q && (rd_off_q == count_q - CNT_W'(1))) begin
          if (!rsp_full_i) begin
            rsp_push_o = 1'b1;
            status     = ST_NOTFOUND;
            rd_vld_d   = 1'b0;
            state_d    = S_IDLE;
          end
        end else if (issue_q < count_q) begin
          rd_en    = 1'b1;
          rd_off_d = issue_q;
          issue_d  = issue_q + CNT_W'(1);
          rd_vld_d = 1'b1;
        end else begin
          rd_vld_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_o.status    = status;
    rsp_o.position  = to_field(position);
    rsp_o.occupancy = to_field(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      front_q  <= '0;
      count_q  <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    rd_off_q <= rd_off_d;
    key_q    <= key_d;
  end

  // element store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= op_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

endmodule

// File: hw/rtl/bounded_deque_with_search_top.sv
// Bounded double-ended queue of signed 32-bit values with search.
// Request channel: push / full with req_i (command, value); a request is
// taken at a clock edge with push high and full low. Result channel:
// empty / pop with rsp_o (status, position, occupancy); the oldest result
// is shown while empty is low and is taken at an edge with pop high.
// Every request gives exactly one result, in request order.
// Inserts, removals, unused codes and searches of an empty store give
// their result without a scan, at one per cycle while the result queue
// has room. A search holds the back end until it matches or has compared
// every held element: the scan reads one element per cycle through the
// store's single read port.
// A two-entry operation queue and a two-entry result queue sit on either
// side of the back end; a stalled receiver fills the result queue, then
// the back end waits and the operation queue fills until full rises.
// Reset empties the store and both queues; no clearing pass is needed.
// Depends on bdq_pkg, bdq_fifo, bdq_front, bdq_back.
module bounded_deque_with_search_top #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  bdq_pkg::req_t req_i,
  output logic          empty,
  input  logic          pop,
  output bdq_pkg::rsp_t rsp_o
);
  import bdq_pkg::*;

  logic op_valid, op_pop;
  op_t  op;
  logic rsp_push, rsp_full;
  rsp_t rsp;

  // request decode and operation queue
  bdq_front #(
    .QueueDepth(QUEUE_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .req_i     (req_i),
    .full_o    (full),
    .op_valid_o(op_valid),
    .op_pop_i  (op_pop),
    .op_o      (op)
  );

  // store and execution
  bdq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_valid_i(op_valid),
    .op_i      (op),
    .op_pop_o  (op_pop),
    .rsp_full_i(rsp_full),
    .rsp_push_o(rsp_push),
    .rsp_o     (rsp)
  );

  // result queue toward the receiver
  bdq_fifo #(
    .T    (rsp_t),
    .Depth(QUEUE_DEPTH)
  ) u_rsp_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rsp_push),
    .data_i (rsp),
    .full_o (rsp_full),
    .pop_i  (pop),
    .data_o (rsp_o),
    .empty_o(empty)
  );

endmodule

// File: hw/rtl/bdq_checker.sv
// bdq_checker: port-level checks on the bounded deque top level
// depends on bdq_pkg; bound to bounded_deque_with_search_top below
module bdq_checker #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          empty,
  input logic          pop,
  input bdq_pkg::rsp_t rsp_o
);
  import bdq_pkg::*;

  // a refused insert reports a store filled to the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.status == ST_FULL) |->
      ((DEPTH > 31) || rsp_o.occupancy == POS_W'(DEPTH)))
    else $error("full status with occupancy below depth");

  // an empty status reports no elements held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.status == ST_EMPTY) |-> (rsp_o.occupancy == '0))
    else $error("empty status with elements held");

  // a position is only given by a successful search within the held elements
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.position != '0) |->
      (rsp_o.status == ST_OK && ((DEPTH > 31) || rsp_o.position <= rsp_o.occupancy)))
    else $error("position outside a successful search");

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rsp_o)))
    else $error("waiting result changed or vanished");

endmodule

bind bounded_deque_with_search_top bdq_checker #(
  .DEPTH(DEPTH)
) u_bdq_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .empty (empty),
  .pop   (pop),
  .rsp_o (rsp_o)
);

// File: tb/sv/tb_bounded_deque_with_search_top.sv
// tb_bounded_deque_with_search_top: self-checking testbench of the bounded deque with search
// predicts each result from a local copy of the store and checks results in order
// depends on bdq_pkg and bounded_deque_with_search_top
module tb_bounded_deque_with_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEF;
  localparam int unsigned QUIET_MAX  = 2000;
  localparam int unsigned DRAIN_WAIT = 40;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  push   = 1'b0;
  logic  pop    = 1'b0;
  req_t  req    = '0;
  logic  full;
  logic  empty;
  rsp_t  rsp_o;

  // local copy of the store
  logic [VAL_W-1:0] deque_cells [DEPTH];
  int unsigned      head_cell  = 0;
  int unsigned      held_count = 0;

  rsp_t        pending_rsps [$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;

  // sender burst and receiver stall controls
  int unsigned tx_gap_max    = 0;
  int unsigned tx_burst_max  = 1;
  int unsigned tx_burst_left = 0;
  int unsigned rx_stall_max  = 0;
  int unsigned rx_run_max    = 1;
  int unsigned rx_left       = 0;
  bit          rx_popping    = 1'b0;

  bounded_deque_with_search_top #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req),
    .empty (empty),
    .pop   (pop),
    .rsp_o (rsp_o)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // apply one command to the local store and return its result
  function automatic rsp_t deque_apply(req_t r);
    rsp_t        rsp;
    bit          hit;
    int unsigned i;
    rsp.status   = ST_OK;
    rsp.position = '0;
    hit          = 1'b0;
    case (r.command)
      CMD_INS_FRONT: begin
        if (held_count >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          head_cell = (head_cell + DEPTH - 1) % DEPTH;
          deque_cells[head_cell] = r.value;
          held_count++;
        end
      end
      CMD_INS_REAR: begin
        if (held_count >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          deque_cells[(head_cell + held_count) % DEPTH] = r.value;
          held_count++;
        end
      end
      CMD_REM_FRONT: begin
        if (held_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          head_cell = (head_cell + 1) % DEPTH;
          held_count--;
        end
      end
      CMD_REM_REAR: begin
        if (held_count == 0) rsp.status = ST_EMPTY;
        else held_count--;
      end
      CMD_SEARCH: begin
        if (held_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.status = ST_NOTFOUND;
          for (i = 0; i < held_count; i++) begin
            if (!hit && deque_cells[(head_cell + i) % DEPTH] == r.value) begin
              hit          = 1'b1;
              rsp.status   = ST_OK;
              rsp.position = POS_W'(i + 1);
            end
          end
        end
      end
      default: begin
        // unused codes leave the store alone
      end
    endcase
    rsp.occupancy = POS_W'(held_count);
    return rsp;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    error_count++;
  endtask

  // send one request, idling between bursts
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
    int unsigned gap;
    req_t        r;
    r.command = cmd;
    r.value   = val;
    if (tx_burst_left == 0) begin
      if (tx_gap_max > 0) begin
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      tx_burst_left = $urandom_range(tx_burst_max, 1);
    end
    tx_burst_left--;
    push <= 1'b1;
    req  <= r;
    do @(posedge clk_i); while (full);
    pending_rsps.push_back(deque_apply(r));
  endtask

  // value mix: small pool for duplicates, extremes, full-width random
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 40) return VAL_W'($signed($urandom_range(7, 0)) - 4);
    if (roll < 55) begin
      case ($urandom_range(3, 0))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // random commands with given insert and removal weights in percent
  task automatic run_random(input int unsigned n, input int unsigned ins_pct,
                            input int unsigned rem_pct);
    int unsigned      k;
    int unsigned      roll;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] val;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(99, 0);
      val  = pick_value();
      if (roll < 3) begin
        cmd = CMD_W'($urandom_range(7, 5));
      end else if (roll < 3 + ins_pct) begin
        cmd = $urandom_range(1, 0) ? CMD_INS_FRONT : CMD_INS_REAR;
      end else if (roll < 3 + ins_pct + rem_pct) begin
        cmd = $urandom_range(1, 0) ? CMD_REM_FRONT : CMD_REM_REAR;
      end else begin
        cmd = CMD_SEARCH;
        // mostly search for something that is held
        if (held_count > 0 && $urandom_range(99, 0) < 60)
          val = deque_cells[(head_cell + $urandom_range(held_count - 1, 0)) % DEPTH];
      end
      send_request(cmd, val);
    end
  endtask

  // empty, unused, extreme values, full store, last-position search
  task automatic test_directed_corners();
    int unsigned i;
    tx_gap_max   = 0;
    rx_stall_max = 4;
    rx_run_max   = 4;
    send_request(CMD_REM_FRONT, 32'h1234_5678);
    send_request(CMD_REM_REAR, 32'h0);
    send_request(CMD_SEARCH, 32'h0);
    send_request(3'd5, 32'hffff_ffff);
    send_request(3'd7, 32'h0);
    send_request(CMD_INS_FRONT, 32'h8000_0000);
    send_request(CMD_INS_REAR, 32'h7fff_ffff);
    send_request(CMD_SEARCH, 32'h8000_0000);
    send_request(CMD_SEARCH, 32'h7fff_ffff);
    send_request(CMD_SEARCH, 32'h0);
    for (i = 0; i < DEPTH - 3; i++) send_request(CMD_INS_REAR, 32'h100 + i);
    send_request(CMD_INS_REAR, 32'h5a5a_0010);
    send_request(CMD_INS_FRONT, 32'h1);
    send_request(CMD_INS_REAR, 32'h2);
    send_request(CMD_SEARCH, 32'h5a5a_0010);
    send_request(CMD_REM_FRONT, 32'h0);
    send_request(CMD_REM_REAR, 32'h0);
  endtask

  // fill, drain and balanced phases under varying idle patterns
  task automatic test_random_commands();
    int unsigned ph;
    for (ph = 0; ph < 8; ph++) begin
      case ($urandom_range(2, 0))
        0: tx_gap_max = 0;
        1: tx_gap_max = 3;
        default: tx_gap_max = 12;
      endcase
      tx_burst_max = $urandom_range(8, 1);
      case ($urandom_range(2, 0))
        0: rx_stall_max = 0;
        1: rx_stall_max = 4;
        default: rx_stall_max = 20;
      endcase
      rx_run_max = $urandom_range(8, 1);
      case (ph % 3)
        0: run_random(150, 60, 15);
        1: run_random(150, 15, 60);
        default: run_random(150, 35, 30);
      endcase
    end
  endtask

  // back-to-back requests with the receiver always ready
  task automatic test_streaming();
    tx_gap_max   = 0;
    rx_stall_max = 0;
    run_random(300, 35, 30);
  endtask

  // long receiver stalls so that full rises, with long scans
  task automatic test_backpressure();
    tx_gap_max   = 0;
    rx_stall_max = 40;
    rx_run_max   = 3;
    run_random(250, 30, 20);
  endtask

  // result checker and no-progress counter
  always @(posedge clk_i) begin : result_check
    rsp_t exp_rsp;
    if (rst_ni && pop && !empty) begin
      if (pending_rsps.size() == 0) begin
        report_mismatch("result with no request pending", 32'(rsp_o), 32'd0);
      end else begin
        exp_rsp = pending_rsps.pop_front();
        if (rsp_o.status !== exp_rsp.status)
          report_mismatch("status", 32'(rsp_o.status), 32'(exp_rsp.status));
        if (rsp_o.position !== exp_rsp.position)
          report_mismatch("position", 32'(rsp_o.position), 32'(exp_rsp.position));
        if (rsp_o.occupancy !== exp_rsp.occupancy)
          report_mismatch("occupancy", 32'(rsp_o.occupancy), 32'(exp_rsp.occupancy));
      end
    end
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // receiver pop pattern: runs of pops and stalls
  always @(posedge clk_i) begin : pop_pattern
    if (rx_left == 0) begin
      if (rx_popping && rx_stall_max > 0) begin
        rx_popping = 1'b0;
        rx_left    = $urandom_range(rx_stall_max, 1);
      end else begin
        rx_popping = 1'b1;
        rx_left    = $urandom_range(rx_run_max, 1);
      end
    end
    rx_left--;
    pop <= rst_ni & rx_popping;
  end

  // watchdog on cycles without any accepted request or result
  initial begin : watchdog
    while (quiet_cycles < QUIET_MAX) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // test sequence
  initial begin : main_seq
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_random_commands();
    test_streaming();
    test_backpressure();
    push <= 1'b0;
    while (pending_rsps.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_fifo.sv
hw/rtl/bdq_front.sv
hw/rtl/bdq_back.sv
hw/rtl/bounded_deque_with_search_top.sv
hw/rtl/bdq_checker.sv
tb/sv/tb_bounded_deque_with_search_top.sv
